// ===== rtl/vns2d_pkg.sv =====
// Shared constants, types and datapath helpers for the 2D value noise sampler.
`default_nettype none

package vns2d_pkg;

  typedef logic [31:0]        hash_t;
  typedef logic [23:0]        q24_t;
  typedef logic [24:0]        weight_t;   // 0 .. 2^24
  typedef logic signed [50:0] lprod_t;    // (b - a) * w

  localparam hash_t   K_X     = 32'h27D4EB2D;
  localparam hash_t   K_Z     = 32'h165667B1;
  localparam hash_t   MIX_C1  = 32'h85EBCA6B;
  localparam hash_t   MIX_C2  = 32'hC2B2AE35;
  localparam int      SHR_A   = 15;
  localparam int      SHR_B   = 13;
  localparam int      SHR_C   = 16;
  localparam q24_t    MAX24   = 24'hFFFFFF;
  localparam q24_t    HALF24  = 24'h800000;
  localparam weight_t ONE24   = 25'h1000000;
  localparam logic [25:0] THREE24 = 26'h3000000;

  // (f*f + half) >> 24, fits 24 bits for f < 2^24
  function automatic q24_t square_q24(input q24_t f);
    logic [47:0] p;
    logic [47:0] s;
    begin
      p = 48'(f) * 48'(f);
      s = p + 48'(HALF24);
      square_q24 = s[47:24];
    end
  endfunction

  // smoothstep weight: (sq * (3 - 2f) + half) >> 24, capped at 1.0
  function automatic weight_t smooth_weight(input q24_t sq, input q24_t f);
    logic [25:0] fac;
    logic [49:0] p;
    logic [49:0] s;
    begin
      fac = THREE24 - {1'b0, f, 1'b0};
      p   = 50'(sq) * 50'(fac);
      s   = p + 50'(HALF24);
      if (s[49:24] > 26'(ONE24)) begin
        smooth_weight = ONE24;
      end else begin
        smooth_weight = s[48:24];
      end
    end
  endfunction

  function automatic hash_t mix_first(input hash_t h);
    hash_t t;
    begin
      t = h ^ (h >> SHR_A);
      mix_first = t * MIX_C1;
    end
  endfunction

  function automatic hash_t mix_second(input hash_t h);
    hash_t t;
    begin
      t = h ^ (h >> SHR_B);
      mix_second = t * MIX_C2;
    end
  endfunction

  function automatic q24_t mix_final(input hash_t h);
    hash_t t;
    begin
      t = h ^ (h >> SHR_C);
      mix_final = t[31:8];
    end
  endfunction

  // a + (b - a) * w, product half
  function automatic lprod_t lerp_prod(input q24_t a, input q24_t b, input weight_t w);
    logic signed [24:0] d;
    logic signed [25:0] ws;
    begin
      d  = $signed({1'b0, b}) - $signed({1'b0, a});
      ws = $signed({1'b0, w});
      lerp_prod = d * ws;
    end
  endfunction

  // (a << 24) + p + half, >> 24, saturated to 0 .. MAX24
  function automatic q24_t lerp_finish(input q24_t a, input lprod_t p);
    lprod_t s;
    begin
      s = $signed({3'b000, a, 24'h000000}) + p + $signed({27'd0, HALF24});
      if (s[50]) begin
        lerp_finish = '0;
      end else if (|s[49:48]) begin
        lerp_finish = MAX24;
      end else begin
        lerp_finish = s[47:24];
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/value_noise_2d_sampler.sv =====
// Top level: seven-stage pipelined 2D value noise sampler with seed register.
//
//   channel   dir   handshake                 beat
//   in        in    in_valid_i / in_ready_o   coord_x_i, coord_z_i
//   out       out   out_valid_o / out_ready_i noise_value_o
//   cfg       in    cfg_valid_i / cfg_ready_o cfg_data_i (noise seed)
//
// One beat per clock while out_ready_i is high; each stage ends in a register.
// Depth is set by the lattice scaling multiply, the two hash mix multiplies and
// the two blend multiply/add pairs.
// Each stage has its own valid bit and loads when empty or when the next stage
// moves, so bubbles are squeezed out and a stall holds the full run behind it.
// rst_ni clears the valid bits and the seed (seed resets to 0).
`default_nettype none

module value_noise_2d_sampler #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [31:0] coord_x_i,
  input  wire logic [31:0] coord_z_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [23:0] noise_value_o
);

  localparam int unsigned NSTG = 7;

  vns2d_pkg::hash_t seed_q;

  logic [NSTG:1]   v_q;
  logic [NSTG:1]   vin;
  logic [NSTG+1:1] rdy;

  // seed register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  // pipeline control
  always_comb begin
    rdy[NSTG+1] = out_ready_i;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign vin        = {v_q[NSTG-1:1], in_valid_i};
  assign in_ready_o = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  // stage 1: floor to cell, scale lattice index, square the fractions
  logic signed [31:0] cell_x, cell_z;
  vns2d_pkg::q24_t    fx_d, fz_d;
  vns2d_pkg::hash_t   s1_px_q, s1_pz_q;
  vns2d_pkg::q24_t    s1_fx_q, s1_fz_q, s1_sqx_q, s1_sqz_q;

  assign cell_x = $signed(coord_x_i) >>> FRAC_BITS;
  assign cell_z = $signed(coord_z_i) >>> FRAC_BITS;
  assign fx_d   = 24'(coord_x_i[FRAC_BITS-1:0]) << (24 - FRAC_BITS);
  assign fz_d   = 24'(coord_z_i[FRAC_BITS-1:0]) << (24 - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vin[1]) begin
      s1_px_q  <= cell_x * vns2d_pkg::K_X;
      s1_pz_q  <= cell_z * vns2d_pkg::K_Z;
      s1_fx_q  <= fx_d;
      s1_fz_q  <= fz_d;
      s1_sqx_q <= vns2d_pkg::square_q24(fx_d);
      s1_sqz_q <= vns2d_pkg::square_q24(fz_d);
    end
  end

  // stage 2: corner seeds, first mix multiply, smoothstep weights
  // (x0+1)*K = x0*K + K mod 2^32
  vns2d_pkg::hash_t   px1, pz1;
  vns2d_pkg::hash_t   h0 [4];
  vns2d_pkg::hash_t   s2_h_q [4];
  vns2d_pkg::weight_t s2_wx_q, s2_wz_q;

  assign px1   = s1_px_q + vns2d_pkg::K_X;
  assign pz1   = s1_pz_q + vns2d_pkg::K_Z;
  assign h0[0] = seed_q ^ s1_px_q ^ s1_pz_q;   // (x0, z0)
  assign h0[1] = seed_q ^ px1     ^ s1_pz_q;   // (x1, z0)
  assign h0[2] = seed_q ^ s1_px_q ^ pz1;       // (x0, z1)
  assign h0[3] = seed_q ^ px1     ^ pz1;       // (x1, z1)

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vin[2]) begin
      for (int c = 0; c < 4; c++) begin
        s2_h_q[c] <= vns2d_pkg::mix_first(h0[c]);
      end
      s2_wx_q <= vns2d_pkg::smooth_weight(s1_sqx_q, s1_fx_q);
      s2_wz_q <= vns2d_pkg::smooth_weight(s1_sqz_q, s1_fz_q);
    end
  end

  // stage 3: second mix multiply
  vns2d_pkg::hash_t   s3_h_q [4];
  vns2d_pkg::weight_t s3_wx_q, s3_wz_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && vin[3]) begin
      for (int c = 0; c < 4; c++) begin
        s3_h_q[c] <= vns2d_pkg::mix_second(s2_h_q[c]);
      end
      s3_wx_q <= s2_wx_q;
      s3_wz_q <= s2_wz_q;
    end
  end

  // stage 4: corner values, x-blend products
  vns2d_pkg::q24_t    cv [4];
  vns2d_pkg::q24_t    s4_bl_q, s4_tl_q;
  vns2d_pkg::lprod_t  s4_pb_q, s4_pt_q;
  vns2d_pkg::weight_t s4_wz_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cv[c] = vns2d_pkg::mix_final(s3_h_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4] && vin[4]) begin
      s4_bl_q <= cv[0];
      s4_tl_q <= cv[2];
      s4_pb_q <= vns2d_pkg::lerp_prod(cv[0], cv[1], s3_wx_q);
      s4_pt_q <= vns2d_pkg::lerp_prod(cv[2], cv[3], s3_wx_q);
      s4_wz_q <= s3_wz_q;
    end
  end

  // stage 5: finish the x blends
  vns2d_pkg::q24_t    s5_bot_q, s5_top_q;
  vns2d_pkg::weight_t s5_wz_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5] && vin[5]) begin
      s5_bot_q <= vns2d_pkg::lerp_finish(s4_bl_q, s4_pb_q);
      s5_top_q <= vns2d_pkg::lerp_finish(s4_tl_q, s4_pt_q);
      s5_wz_q  <= s4_wz_q;
    end
  end

  // stage 6: z-blend product
  vns2d_pkg::q24_t   s6_bot_q;
  vns2d_pkg::lprod_t s6_p_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6] && vin[6]) begin
      s6_bot_q <= s5_bot_q;
      s6_p_q   <= vns2d_pkg::lerp_prod(s5_bot_q, s5_top_q, s5_wz_q);
    end
  end

  // stage 7: finish the z blend into the output register
  vns2d_pkg::q24_t s7_val_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7] && vin[7]) begin
      s7_val_q <= vns2d_pkg::lerp_finish(s6_bot_q, s6_p_q);
    end
  end

  assign out_valid_o   = v_q[NSTG];
  assign noise_value_o = s7_val_q;

`ifndef SYNTHESIS
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[1])
    else $error("accepted beat did not enter stage 1");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] && !rdy[5] |=> v_q[4])
    else $error("stalled stage 4 lost its beat");

  a_weight_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (s2_wx_q <= vns2d_pkg::ONE24) && (s2_wz_q <= vns2d_pkg::ONE24))
    else $error("smoothstep weight above 1.0");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !v_q[NSTG-1] |=> !out_valid_o)
    else $error("output beat repeated");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[1] |-> in_ready_o)
    else $error("input blocked with empty first stage");
`endif

endmodule

`default_nettype wire
